// File: hw/rtl/lboost_pkg.sv
// shared types for the lorentz boost pipeline
package lboost_pkg;

    // pipeline control handed to each sub-pipeline: advance enable and entry valid
    typedef struct packed {
        logic en;
        logic vld;
    } lboost_ctl_t;

endpackage

// File: hw/rtl/lboost_sqrt.sv
// pipelined integer square root, one root bit per stage, with a sideband carried along
module lboost_sqrt
    import lboost_pkg::*;
#(
    parameter int W  = 32,
    parameter int SW = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lboost_ctl_t       ctl,
    input  logic [2*W-1:0]    rad,
    input  logic [SW-1:0]     side_in,
    output logic              vld_out,
    output logic [W-1:0]      root,
    output logic [SW-1:0]     side_out
);

    logic [2*W:0]  rem_w  [0:W];
    logic [W-1:0]  root_w [0:W];
    logic [SW-1:0] side_w [0:W];
    logic          vld_w  [0:W];

    assign rem_w[0]  = {1'b0, rad};
    assign root_w[0] = '0;
    assign side_w[0] = side_in;
    assign vld_w[0]  = ctl.vld;

    // one stage per root bit, most significant first
    for (genvar g = 0; g < W; g++) begin : g_stage
        localparam int K = W - 1 - g;
        logic [2*W:0]  trial;
        logic [2*W:0]  rem_next;
        logic [2*W:0]  rem_reg;
        logic [W-1:0]  root_next;
        logic [W-1:0]  root_reg;
        logic [SW-1:0] side_reg;
        logic          vld_reg;

        // (r + 2^k)^2 - r^2 = r * 2^(k+1) + 2^(2k)
        always_comb
        begin
            trial = ((2*W+1)'(root_w[g]) << (K + 1)) | ((2*W+1)'(1) << (2 * K));
            if (rem_w[g] >= trial)
            begin
                rem_next  = rem_w[g] - trial;
                root_next = root_w[g] | (W'(1) << K);
            end
            else
            begin
                rem_next  = rem_w[g];
                root_next = root_w[g];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (ctl.en)
            begin
                vld_reg <= vld_w[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                side_reg <= side_w[g];
            end
        end

        assign rem_w[g+1]  = rem_reg;
        assign root_w[g+1] = root_reg;
        assign side_w[g+1] = side_reg;
        assign vld_w[g+1]  = vld_reg;
    end

    assign vld_out  = vld_w[W];
    assign root     = root_w[W];
    assign side_out = side_w[W];

endmodule

// File: hw/rtl/lboost_div.sv
// pipelined restoring divider, several unsigned lanes, one quotient bit per stage
// quotients that do not fit in QB bits come out as all ones
module lboost_div
    import lboost_pkg::*;
#(
    parameter int NB = 97,
    parameter int DB = 65,
    parameter int QB = 33,
    parameter int LN = 4,
    parameter int SW = 1
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lboost_ctl_t               ctl,
    input  logic [LN-1:0][NB-1:0]     num,
    input  logic [LN-1:0][DB-1:0]     den,
    input  logic [SW-1:0]             side_in,
    output logic                      vld_out,
    output logic [LN-1:0][QB-1:0]     quo,
    output logic [SW-1:0]             side_out
);

    localparam int XB = (DB + QB > NB) ? DB + QB : NB;

    logic [LN-1:0][DB-1:0] rem_w  [0:QB];
    logic [LN-1:0][QB-1:0] low_w  [0:QB];
    logic [LN-1:0][QB-1:0] q_w    [0:QB];
    logic [LN-1:0][DB-1:0] den_w  [0:QB];
    logic [LN-1:0]         ovf_w  [0:QB];
    logic [SW-1:0]         side_w [0:QB];
    logic                  vld_w  [0:QB];

    // entry stage: overflow test and initial partial remainder
    logic [LN-1:0][DB-1:0] rem0_next;
    logic [LN-1:0]         ovf0_next;
    logic [LN-1:0][DB-1:0] rem0_reg;
    logic [LN-1:0][QB-1:0] low0_reg;
    logic [LN-1:0][DB-1:0] den0_reg;
    logic [LN-1:0]         ovf0_reg;
    logic [SW-1:0]         side0_reg;
    logic                  vld0_reg;

    always_comb
    begin
        for (int l = 0; l < LN; l++)
        begin
            ovf0_next[l] = XB'(num[l]) >= (XB'(den[l]) << QB);
            rem0_next[l] = DB'(num[l] >> QB);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            vld0_reg <= ctl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rem0_reg  <= rem0_next;
            ovf0_reg  <= ovf0_next;
            den0_reg  <= den;
            side0_reg <= side_in;
            for (int l = 0; l < LN; l++)
            begin
                low0_reg[l] <= num[l][QB-1:0];
            end
        end
    end

    assign rem_w[0]  = rem0_reg;
    assign low_w[0]  = low0_reg;
    assign q_w[0]    = '0;
    assign den_w[0]  = den0_reg;
    assign ovf_w[0]  = ovf0_reg;
    assign side_w[0] = side0_reg;
    assign vld_w[0]  = vld0_reg;

    // one quotient bit per stage
    for (genvar g = 0; g < QB; g++) begin : g_stage
        logic [LN-1:0][DB:0]   rem2;
        logic [LN-1:0][DB-1:0] rem_next;
        logic [LN-1:0][QB-1:0] q_next;
        logic [LN-1:0][DB-1:0] rem_reg;
        logic [LN-1:0][QB-1:0] low_reg;
        logic [LN-1:0][QB-1:0] q_reg;
        logic [LN-1:0][DB-1:0] den_reg;
        logic [LN-1:0]         ovf_reg;
        logic [SW-1:0]         side_reg;
        logic                  vld_reg;

        always_comb
        begin
            for (int l = 0; l < LN; l++)
            begin
                rem2[l] = {rem_w[g][l], low_w[g][l][QB-1]};
                if (rem2[l] >= (DB+1)'(den_w[g][l]))
                begin
                    rem_next[l] = DB'(rem2[l] - (DB+1)'(den_w[g][l]));
                    q_next[l]   = {q_w[g][l][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = DB'(rem2[l]);
                    q_next[l]   = {q_w[g][l][QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (ctl.en)
            begin
                vld_reg <= vld_w[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg  <= rem_next;
                q_reg    <= q_next;
                den_reg  <= den_w[g];
                ovf_reg  <= ovf_w[g];
                side_reg <= side_w[g];
                for (int l = 0; l < LN; l++)
                begin
                    low_reg[l] <= {low_w[g][l][QB-2:0], 1'b0};
                end
            end
        end

        assign rem_w[g+1]  = rem_reg;
        assign low_w[g+1]  = low_reg;
        assign q_w[g+1]    = q_reg;
        assign den_w[g+1]  = den_reg;
        assign ovf_w[g+1]  = ovf_reg;
        assign side_w[g+1] = side_reg;
        assign vld_w[g+1]  = vld_reg;
    end

    // clamp overflowed lanes
    always_comb
    begin
        for (int l = 0; l < LN; l++)
        begin
            quo[l] = ovf_w[QB][l] ? {QB{1'b1}} : q_w[QB][l];
        end
    end

    assign vld_out  = vld_w[QB];
    assign side_out = side_w[QB];

endmodule

// File: hw/rtl/lorentz_boost.sv
// lorentz boost of a daughter four-vector into the lab frame of its parent
// throughput: one request per cycle; the whole pipeline holds while the output waits
// depth is set mainly by the square root (one bit per stage) and the divider (one quotient bit per stage)
// reset: asynchronous, active low; clears all valid bits, the pipeline comes up empty
module lorentz_boost
    import lboost_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // parent_px, parent_py, parent_pz, parent_energy,
    // daughter_px, daughter_py, daughter_pz, daughter_energy
    input  logic [((8*WORD_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // boosted_px, boosted_py, boosted_pz, boosted_energy
    output logic [((4*WORD_BITS+7)/8)*8-1:0]    m_tdata,
    // invalid
    output logic                                m_tuser
);

    localparam int W      = WORD_BITS;
    localparam int OUT_TW = ((4*WORD_BITS+7)/8)*8;
    localparam int SQ_SW  = 10*W + 3;
    localparam int DV_SW  = 3*W + 5;
    localparam int NB     = 3*W + 1;
    localparam int DB     = 2*W + 1;
    localparam int QB     = W + 1;
    localparam logic signed [W+2:0] SMAX = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0] SMIN = {4'b1111, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] sat_word(input logic signed [W+2:0] x);
        logic signed [W-1:0] r;
        if (x > SMAX)
        begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        else if (x < SMIN)
        begin
            r = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            r = x[W-1:0];
        end
        return r;
    endfunction

    logic        en;
    logic        out_vld_reg;

    // whole pipeline moves when the output register is free or drained
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_vld_reg;

    // input words
    logic signed [W-1:0] in_p [0:2];
    logic signed [W-1:0] in_d [0:2];
    logic signed [W-1:0] in_e;
    logic signed [W-1:0] in_ed;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_p[i] = s_tdata[i*W +: W];
            in_d[i] = s_tdata[(i+4)*W +: W];
        end
        in_e  = s_tdata[3*W +: W];
        in_ed = s_tdata[7*W +: W];
    end

    // stage a: squares and dot-product terms
    logic signed [2*W-1:0] psq_reg [0:2];
    logic signed [2*W-1:0] dp_reg  [0:2];
    logic signed [2*W-1:0] esq_reg;
    logic signed [W-1:0]   p_a_reg [0:2];
    logic signed [W-1:0]   d_a_reg [0:2];
    logic signed [W-1:0]   e_a_reg;
    logic signed [W-1:0]   ed_a_reg;
    logic                  vld_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                psq_reg[i] <= (2*W)'(in_p[i]) * (2*W)'(in_p[i]);
                dp_reg[i]  <= (2*W)'(in_d[i]) * (2*W)'(in_p[i]);
                p_a_reg[i] <= in_p[i];
                d_a_reg[i] <= in_d[i];
            end
            esq_reg  <= (2*W)'(in_e) * (2*W)'(in_e);
            e_a_reg  <= in_e;
            ed_a_reg <= in_ed;
        end
    end

    // stage b: mass squared, dot product, validity
    logic signed [2*W+1:0] m2_next;
    logic signed [2*W+1:0] dot_next;
    logic                  inv_next;
    logic [W-1:0]          eabs_next;
    logic [2*W-1:0]        rad_reg;
    logic [SQ_SW-1:0]      side_b_reg;
    logic                  vld_b_reg;

    always_comb
    begin
        m2_next  = (2*W+2)'(esq_reg) - (2*W+2)'(psq_reg[0])
                 - (2*W+2)'(psq_reg[1]) - (2*W+2)'(psq_reg[2]);
        dot_next = (2*W+2)'(dp_reg[0]) + (2*W+2)'(dp_reg[1]) + (2*W+2)'(dp_reg[2]);
        inv_next = m2_next[2*W+1] || (m2_next == '0);
        eabs_next = e_a_reg[W-1] ? W'(-e_a_reg) : W'(e_a_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg    <= inv_next ? '0 : m2_next[2*W-1:0];
            side_b_reg <= {inv_next, eabs_next, dot_next, ed_a_reg,
                           p_a_reg[2], p_a_reg[1], p_a_reg[0],
                           d_a_reg[2], d_a_reg[1], d_a_reg[0]};
        end
    end

    // parent mass
    logic [W-1:0]     mass_s;
    logic [SQ_SW-1:0] side_s;
    logic             vld_s;
    lboost_ctl_t      sq_ctl;

    assign sq_ctl.en  = en;
    assign sq_ctl.vld = vld_b_reg;

    lboost_sqrt #(
        .W  (W),
        .SW (SQ_SW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sq_ctl),
        .rad      (rad_reg),
        .side_in  (side_b_reg),
        .vld_out  (vld_s),
        .root     (mass_s),
        .side_out (side_s)
    );

    logic                  s_inv;
    logic [W-1:0]          s_eabs;
    logic signed [2*W+1:0] s_dot;
    logic signed [W-1:0]   s_ed;
    logic signed [W-1:0]   s_p0, s_p1, s_p2;
    logic signed [W-1:0]   s_d0, s_d1, s_d2;

    assign {s_inv, s_eabs, s_dot, s_ed, s_p2, s_p1, s_p0, s_d2, s_d1, s_d0} = side_s;

    // stage c: |E| + m
    logic [W:0]            s_c_reg;
    logic [W-1:0]          mass_c_reg;
    logic [W-1:0]          eabs_c_reg;
    logic signed [2*W+1:0] dot_c_reg;
    logic signed [W-1:0]   ed_c_reg;
    logic signed [W-1:0]   p_c_reg [0:2];
    logic signed [W-1:0]   d_c_reg [0:2];
    logic                  inv_c_reg;
    logic                  vld_c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_c_reg    <= (W+1)'(s_eabs) + (W+1)'(mass_s);
            mass_c_reg <= mass_s;
            eabs_c_reg <= s_eabs;
            dot_c_reg  <= s_dot;
            ed_c_reg   <= s_ed;
            p_c_reg[0] <= s_p0;
            p_c_reg[1] <= s_p1;
            p_c_reg[2] <= s_p2;
            d_c_reg[0] <= s_d0;
            d_c_reg[1] <= s_d1;
            d_c_reg[2] <= s_d2;
            inv_c_reg  <= s_inv;
        end
    end

    // stage d: Ed*(|E|+m), m*(|E|+m), |E|*Ed
    logic signed [2*W+1:0] eds_d_reg;
    logic [2*W:0]          den_d_reg;
    logic signed [2*W:0]   ee_d_reg;
    logic [W-1:0]          mass_d_reg;
    logic signed [2*W+1:0] dot_d_reg;
    logic signed [W-1:0]   p_d_reg [0:2];
    logic signed [W-1:0]   d_d_reg [0:2];
    logic                  inv_d_reg;
    logic                  vld_d_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eds_d_reg  <= (2*W+2)'(ed_c_reg) * (2*W+2)'($signed({1'b0, s_c_reg}));
            den_d_reg  <= (2*W+1)'(mass_c_reg) * (2*W+1)'(s_c_reg);
            ee_d_reg   <= (2*W+1)'($signed({1'b0, eabs_c_reg})) * (2*W+1)'(ed_c_reg);
            mass_d_reg <= mass_c_reg;
            dot_d_reg  <= dot_c_reg;
            p_d_reg    <= p_c_reg;
            d_d_reg    <= d_c_reg;
            inv_d_reg  <= inv_c_reg;
        end
    end

    // stage e: momentum and energy numerators
    logic signed [2*W+2:0] num_e_reg;
    logic signed [2*W+2:0] ne_e_reg;
    logic [2*W:0]          den_e_reg;
    logic [W-1:0]          mass_e_reg;
    logic signed [W-1:0]   p_e_reg [0:2];
    logic signed [W-1:0]   d_e_reg [0:2];
    logic                  inv_e_reg;
    logic                  vld_e_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_e_reg  <= (2*W+3)'(dot_d_reg) + (2*W+3)'(eds_d_reg);
            ne_e_reg   <= (2*W+3)'(dot_d_reg) + (2*W+3)'(ee_d_reg);
            den_e_reg  <= den_d_reg;
            mass_e_reg <= mass_d_reg;
            p_e_reg    <= p_d_reg;
            d_e_reg    <= d_d_reg;
            inv_e_reg  <= inv_d_reg;
        end
    end

    // stage f: sign and magnitude
    logic [2*W+2:0]      nabs_next;
    logic [2*W+2:0]      neabs_next;
    logic [W-1:0]        pabs_next [0:2];
    logic [2*W:0]        nmag_f_reg;
    logic                nsg_f_reg;
    logic [2*W:0]        nemag_f_reg;
    logic                nesg_f_reg;
    logic [W-1:0]        pmag_f_reg [0:2];
    logic                psg_f_reg  [0:2];
    logic [2*W:0]        den_f_reg;
    logic [W-1:0]        mass_f_reg;
    logic signed [W-1:0] d_f_reg [0:2];
    logic                inv_f_reg;
    logic                vld_f_reg;

    always_comb
    begin
        nabs_next  = num_e_reg[2*W+2] ? (2*W+3)'(-num_e_reg) : (2*W+3)'(num_e_reg);
        neabs_next = ne_e_reg[2*W+2] ? (2*W+3)'(-ne_e_reg) : (2*W+3)'(ne_e_reg);
        for (int i = 0; i < 3; i++)
        begin
            pabs_next[i] = p_e_reg[i][W-1] ? W'(-p_e_reg[i]) : W'(p_e_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_f_reg  <= nabs_next[2*W:0];
            nsg_f_reg   <= num_e_reg[2*W+2];
            nemag_f_reg <= neabs_next[2*W:0];
            nesg_f_reg  <= ne_e_reg[2*W+2];
            for (int i = 0; i < 3; i++)
            begin
                pmag_f_reg[i] <= pabs_next[i];
                psg_f_reg[i]  <= p_e_reg[i][W-1];
            end
            den_f_reg  <= den_e_reg;
            mass_f_reg <= mass_e_reg;
            d_f_reg    <= d_e_reg;
            inv_f_reg  <= inv_e_reg;
        end
    end

    // stage g: partial products of p * numerator
    logic [2*W-1:0]      lo_g_reg [0:2];
    logic [2*W:0]        hi_g_reg [0:2];
    logic                qsg_g_reg [0:2];
    logic [2*W:0]        nemag_g_reg;
    logic                nesg_g_reg;
    logic [2*W:0]        den_g_reg;
    logic [W-1:0]        mass_g_reg;
    logic signed [W-1:0] d_g_reg [0:2];
    logic                inv_g_reg;
    logic                vld_g_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_g_reg[i]  <= (2*W)'(pmag_f_reg[i]) * (2*W)'(nmag_f_reg[W-1:0]);
                hi_g_reg[i]  <= (2*W+1)'(pmag_f_reg[i]) * (2*W+1)'(nmag_f_reg[2*W:W]);
                qsg_g_reg[i] <= psg_f_reg[i] ^ nsg_f_reg;
            end
            nemag_g_reg <= nemag_f_reg;
            nesg_g_reg  <= nesg_f_reg;
            den_g_reg   <= den_f_reg;
            mass_g_reg  <= mass_f_reg;
            d_g_reg     <= d_f_reg;
            inv_g_reg   <= inv_f_reg;
        end
    end

    // stage h: combine partial products
    logic [NB-1:0]       prod_h_reg [0:2];
    logic                qsg_h_reg  [0:2];
    logic [2*W:0]        nemag_h_reg;
    logic                nesg_h_reg;
    logic [2*W:0]        den_h_reg;
    logic [W-1:0]        mass_h_reg;
    logic signed [W-1:0] d_h_reg [0:2];
    logic                inv_h_reg;
    logic                vld_h_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_h_reg[i] <= (NB'(hi_g_reg[i]) << W) + NB'(lo_g_reg[i]);
            end
            qsg_h_reg   <= qsg_g_reg;
            nemag_h_reg <= nemag_g_reg;
            nesg_h_reg  <= nesg_g_reg;
            den_h_reg   <= den_g_reg;
            mass_h_reg  <= mass_g_reg;
            d_h_reg     <= d_g_reg;
            inv_h_reg   <= inv_g_reg;
        end
    end

    // valid chain through the fixed stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
            vld_g_reg <= 1'b0;
            vld_h_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= s_tvalid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_s;
            vld_d_reg <= vld_c_reg;
            vld_e_reg <= vld_d_reg;
            vld_f_reg <= vld_e_reg;
            vld_g_reg <= vld_f_reg;
            vld_h_reg <= vld_g_reg;
        end
    end

    // three momentum lanes and the energy lane
    logic [3:0][NB-1:0] div_num;
    logic [3:0][DB-1:0] div_den;
    logic [3:0][QB-1:0] div_q;
    logic [DV_SW-1:0]   div_side;
    logic               vld_v;
    lboost_ctl_t        dv_ctl;

    assign dv_ctl.en  = en;
    assign dv_ctl.vld = vld_h_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            div_num[i] = prod_h_reg[i];
            div_den[i] = den_h_reg;
        end
        div_num[3] = NB'(nemag_h_reg);
        div_den[3] = DB'(mass_h_reg);
    end

    lboost_div #(
        .NB (NB),
        .DB (DB),
        .QB (QB),
        .LN (4),
        .SW (DV_SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (dv_ctl),
        .num      (div_num),
        .den      (div_den),
        .side_in  ({inv_h_reg, nesg_h_reg, qsg_h_reg[2], qsg_h_reg[1], qsg_h_reg[0],
                    d_h_reg[2], d_h_reg[1], d_h_reg[0]}),
        .vld_out  (vld_v),
        .quo      (div_q),
        .side_out (div_side)
    );

    logic                v_inv;
    logic                v_esg;
    logic                v_qsg [0:2];
    logic signed [W-1:0] v_d   [0:2];

    assign {v_inv, v_esg, v_qsg[2], v_qsg[1], v_qsg[0], v_d[2], v_d[1], v_d[0]} = div_side;

    // output stage: apply signs, add daughter momentum, saturate, zero all words of an invalid result
    logic signed [W+2:0] qv_next [0:3];
    logic signed [W-1:0] res_next [0:3];
    logic signed [W-1:0] res_reg  [0:3];
    logic                inv_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            qv_next[i] = $signed((W+3)'(div_q[i]));
        end
        for (int i = 0; i < 3; i++)
        begin
            if (v_qsg[i])
            begin
                qv_next[i] = -qv_next[i];
            end
            res_next[i] = sat_word((W+3)'(v_d[i]) + qv_next[i]);
        end
        if (v_esg)
        begin
            qv_next[3] = -qv_next[3];
        end
        res_next[3] = sat_word(qv_next[3]);
        if (v_inv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                res_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            inv_reg <= v_inv;
        end
    end

    assign m_tdata = OUT_TW'({res_reg[3], res_reg[2], res_reg[1], res_reg[0]});
    assign m_tuser = inv_reg;

endmodule

// File: dv/lorentz_boost_tb.sv
// self-checking testbench for the lorentz boost pipeline
`timescale 1ns / 1ps

module lorentz_boost_tb;

    import lboost_pkg::*;

    localparam int WORD_BITS  = 32;
    localparam int LATENCY    = 2*WORD_BITS + 11;
    localparam int CYCLE_CAP  = 3000000;
    localparam int RAND_ITEMS = 440;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef struct packed {
        word_t p_x;
        word_t p_y;
        word_t p_z;
        word_t p_e;
        word_t d_x;
        word_t d_y;
        word_t d_z;
        word_t d_e;
    } pair_t;

    typedef struct packed {
        word_t b_x;
        word_t b_y;
        word_t b_z;
        word_t b_e;
        logic  bad;
    } boosted_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;

    boosted_t     boost_queue[$];
    bit           failed;
    int           cycles;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_cycles;

    lorentz_boost #(.WORD_BITS(WORD_BITS)) dut (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("lorentz_boost regression: fail");
            $finish;
        end
    end

    // saturate a wide value to the signed word range
    function automatic word_t clamp_word(wide_t v);
        wide_t top;
        wide_t bottom;
        top    = (wide_t'(1) <<< (WORD_BITS-1)) - 1;
        bottom = -(wide_t'(1) <<< (WORD_BITS-1));
        if (v > top)
            return top[WORD_BITS-1:0];
        if (v < bottom)
            return bottom[WORD_BITS-1:0];
        return v[WORD_BITS-1:0];
    endfunction

    // expected boosted daughter for one request
    function automatic boosted_t boost_of(pair_t q);
        boosted_t r;
        wide_t px, py, pz, ea, dx, dy, dz, de;
        wide_t m2, mass, c, s, dot, num, den;
        px = q.p_x; py = q.p_y; pz = q.p_z; ea = q.p_e;
        dx = q.d_x; dy = q.d_y; dz = q.d_z; de = q.d_e;
        r = '0;
        m2 = ea*ea - px*px - py*py - pz*pz;
        if (m2 <= 0)
        begin
            r.bad = 1'b1;
            return r;
        end
        if (ea < 0)
            ea = -ea;
        // floor square root, mass fits well under 64 bits
        mass = 0;
        for (int k = 63; k >= 0; k--)
        begin
            c = mass | (wide_t'(1) <<< k);
            if (c*c <= m2)
                mass = c;
        end
        s   = ea + mass;
        dot = dx*px + dy*py + dz*pz;
        num = dot + de*s;
        den = mass*s;
        r.b_x = clamp_word(dx + (px*num)/den);
        r.b_y = clamp_word(dy + (py*num)/den);
        r.b_z = clamp_word(dz + (pz*num)/den);
        r.b_e = clamp_word((ea*de + dot)/mass);
        return r;
    endfunction

    // receiver: random stall, plus long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        boosted_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (boost_queue.size() == 0)
            begin
                $error("unexpected result %h", m_tdata);
                failed = 1'b1;
            end
            else
            begin
                exp_r = boost_queue.pop_front();
                if (m_tdata[31:0] !== exp_r.b_x)
                begin
                    $error("boosted_px exp %h got %h", exp_r.b_x, m_tdata[31:0]);
                    failed = 1'b1;
                end
                if (m_tdata[63:32] !== exp_r.b_y)
                begin
                    $error("boosted_py exp %h got %h", exp_r.b_y, m_tdata[63:32]);
                    failed = 1'b1;
                end
                if (m_tdata[95:64] !== exp_r.b_z)
                begin
                    $error("boosted_pz exp %h got %h", exp_r.b_z, m_tdata[95:64]);
                    failed = 1'b1;
                end
                if (m_tdata[127:96] !== exp_r.b_e)
                begin
                    $error("boosted_energy exp %h got %h", exp_r.b_e, m_tdata[127:96]);
                    failed = 1'b1;
                end
                if (m_tuser !== exp_r.bad)
                begin
                    $error("invalid exp %b got %b", exp_r.bad, m_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    // offer one request and wait for it to be taken
    task automatic send_pair(pair_t q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {q.d_e, q.d_z, q.d_y, q.d_x, q.p_e, q.p_z, q.p_y, q.p_x};
        do
            @(posedge clk);
        while (!s_tready);
        boost_queue.push_back(boost_of(q));
    endtask

    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (boost_queue.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic word_t rand_word();
        return word_t'($urandom) >>> $urandom_range(31);
    endfunction

    // mostly physical parents, some fully random noise
    function automatic pair_t rand_pair();
        pair_t  q;
        longint e;
        int     sh;
        if ($urandom_range(99) < 20)
            q = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        else
        begin
            sh    = $urandom_range(2, 30);
            q.p_x = word_t'($urandom) >>> sh;
            q.p_y = word_t'($urandom) >>> sh;
            q.p_z = ($urandom_range(9) == 0) ? '0 : word_t'($urandom) >>> sh;
            e = (q.p_x < 0 ? -longint'(q.p_x) : longint'(q.p_x))
              + (q.p_y < 0 ? -longint'(q.p_y) : longint'(q.p_y))
              + (q.p_z < 0 ? -longint'(q.p_z) : longint'(q.p_z))
              + longint'($urandom >> $urandom_range(3, 31)) + 1;
            if (e > 64'sh7fffffff)
                e = 64'sh7fffffff;
            q.p_e = $urandom_range(1) ? word_t'(e) : -word_t'(e);
            q.d_x = rand_word();
            q.d_y = rand_word();
            q.d_z = rand_word();
            q.d_e = rand_word();
        end
        return q;
    endfunction

    task automatic test_directed;
        word_t mx, mn, one;
        mx  = 32'sh7fffffff;
        mn  = 32'sh80000000;
        one = 32'sh00010000;
        // all zero: mass not positive
        send_pair('0);
        // parent at rest: pass-through
        send_pair({32'sd0, 32'sd0, 32'sd0, one, one, -one, mx, mn});
        send_pair({32'sd0, 32'sd0, 32'sd0, mn, mx, mn, mx, mn});
        send_pair({32'sd0, 32'sd0, 32'sd0, mx, mn, mx, 32'sd0, 32'sd1});
        send_pair({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd5, -32'sd5, 32'sd7, 32'sd9});
        // lightlike and spacelike parents
        send_pair({one, 32'sd0, 32'sd0, one, one, one, one, one});
        send_pair({mx, mx, mx, mx, one, one, one, one});
        send_pair({mn, mn, mn, mn, mx, mx, mx, mx});
        send_pair({32'sd3, 32'sd4, 32'sd0, -32'sd5, one, 32'sd0, 32'sd0, one});
        // heavy boosts that saturate
        send_pair({32'sd1 <<< 29, 32'sd0, 32'sd0, mx, mx, mx, mx, mx});
        send_pair({-(32'sd1 <<< 29), 32'sd0, 32'sd0, mn, mn, mn, mn, mn});
        send_pair({32'sd0, 32'sh7ffffff0, 32'sd0, mx, mn, mx, mn, mx});
        send_pair({32'sd0, 32'sd0, -32'sh7fff0000, mn, mx, 32'sd0, mn, mx});
        // moderate boosts, both signs of energy
        send_pair({one, 2*one, -3*one, 10*one, one, one, -one, 2*one});
        send_pair({-one, -2*one, 3*one, -10*one, -one, one, one, 2*one});
        send_pair({32'sd1, 32'sd1, 32'sd1, 32'sd2, mx, mn, 32'sd0, mx});
        drain();
    endtask

    task automatic test_random(int idle, int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (RAND_ITEMS)
            send_pair(rand_pair());
        drain();
    endtask

    // long receiver hold-off fills the pipeline, then pause until empty
    task automatic test_backpressure;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 400;
        repeat (150)
            send_pair(rand_pair());
        drain();
    endtask

    initial
    begin
        failed         = 1'b0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(0, 0);
        test_random(80, 0);
        test_random(0, 80);
        test_random(26, 26);
        test_backpressure();

        if (!failed)
            $display("lorentz_boost regression: pass");
        else
            $display("lorentz_boost regression: fail");
        $finish;
    end

endmodule
